// ===== sv/adfid_pkg.sv =====
// Shared types and constants for the audio drift frame insert/drop block.
package adfid_pkg;

  // Default sizes of the block.
  localparam int MAX_FRAMES_DEF  = 4096;
  localparam int DRIFT_WIDTH_DEF = 24;

  // Fixed field widths of the stream items.
  localparam int CNT_W       = 13;
  localparam int DRIFT_IN_W  = 24;
  localparam int SAMPLE_W    = 16;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  // Frames per unit of adjustment at a buffer header is 200. The quotient
  // n/200 equals (n * 5243) >> 20 for every 13-bit frame count n.
  localparam logic [CNT_W-1:0] HDR_RECIP = CNT_W'(5243);
  localparam int               HDR_SHIFT = 20;

  // Item kinds carried in the input tuser; the fourth code is ignored.
  typedef enum logic [1:0] {
    MODE_DRIFT  = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_FRAME  = 2'd2
  } mode_t;

  // One classified input item as it sits in the queue.
  typedef struct packed {
    mode_t                         kind;
    logic signed [DRIFT_IN_W-1:0]  drift;
    logic [CNT_W-1:0]              frames;
    logic [CNT_W-1:0]              spare;
    logic signed [SAMPLE_W-1:0]    left;
    logic signed [SAMPLE_W-1:0]    right;
  } item_t;

  // Request to the shared serial divider.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  // Answer of the shared serial divider.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/audio_drift_frame_insert_drop.sv =====
// Top level of the audio drift compensator: input queue, sequencer and divider.
// A drift item updates the pending drift, and a frame is taken once the output
// register is free; a frame that gets an interpolated neighbor places the neighbor
// and then itself in the output, and a dropped frame or drift item emits nothing. A
// buffer header holds the back end while it is taken (frames/200 by reciprocal
// multiplication), the adjustment T is planned, frames/(T+1) runs on the shared
// divider that yields one quotient bit per cycle, the quotient is taken and the
// first insert or drop point is placed. A two-entry input queue keeps taking items
// meanwhile until it is full, so streaming frames pass at one per cycle while the
// output is not stalled and no neighbor is inserted.
module audio_drift_frame_insert_drop #(
  parameter int MAX_FRAMES  = adfid_pkg::MAX_FRAMES_DEF,
  parameter int DRIFT_WIDTH = adfid_pkg::DRIFT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // drift_amount, frame_count, spare_frames, left_sample, right_sample, zero fill
  input  logic [adfid_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_left, out_right
  output logic [adfid_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // is_inserted
  output logic                                out_tuser,
  // buffer_end
  output logic                                out_tlast
);
  import adfid_pkg::*;

  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  adfid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  adfid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  adfid_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .DRIFT_WIDTH (DRIFT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A full queue always presents a head item to the back end.
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input queue full but no head item");

  // An interpolated frame never closes a buffer.
  a_ins_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("inserted frame marked as buffer end");

  // The original frame follows its inserted neighbor right away.
  a_ins_followed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |=> out_tvalid && !out_tuser)
    else $error("inserted frame not followed by its original");

endmodule

// ===== sv/adfid_front.sv =====
// Input side: accepts items, classifies them and holds them in a two-entry queue.
module adfid_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [adfid_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [1:0]                           in_tuser,
  output logic                                 q_valid,
  output adfid_pkg::item_t                     q_item,
  input  logic                                 q_pop
);
  import adfid_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  item_t      slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       keep;
  logic       push;
  item_t      item_in;

  // Classify the item: the unused kind is accepted and dropped here.
  always_comb begin
    unique case (in_tuser) inside
      MODE_DRIFT, MODE_HEADER, MODE_FRAME: keep = 1'b1;
      default:                             keep = 1'b0;
    endcase
  end

  // Unpack the payload fields from the lowest bit up.
  always_comb begin
    item_in.kind   = mode_t'(in_tuser);
    item_in.drift  = in_tdata[23:0];
    item_in.frames = in_tdata[36:24];
    item_in.spare  = in_tdata[49:37];
    item_in.left   = in_tdata[65:50];
    item_in.right  = in_tdata[81:66];
  end

  assign in_tready = (cnt_r < 2'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/adfid_div.sv =====
// Shared restoring divider: one quotient bit per cycle over the frame count width.
module adfid_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  adfid_pkg::div_req_t   req,
  output adfid_pkg::div_rsp_t   rsp
);
  import adfid_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try the divisor.
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[CNT_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(CNT_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[CNT_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== sv/adfid_back.sv =====
// Execution side: drift bookkeeping, per-buffer planning and frame insert/drop.
module adfid_back #(
  parameter int MAX_FRAMES  = adfid_pkg::MAX_FRAMES_DEF,
  parameter int DRIFT_WIDTH = adfid_pkg::DRIFT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  adfid_pkg::item_t                     q_item,
  output logic                                 q_pop,
  output adfid_pkg::div_req_t                  div_req,
  input  adfid_pkg::div_rsp_t                  div_rsp,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [adfid_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import adfid_pkg::*;

  localparam int MARK_W = CNT_W + 1;
  localparam int SUM_W  = ((DRIFT_WIDTH > DRIFT_IN_W) ? DRIFT_WIDTH : DRIFT_IN_W) + 1;
  localparam logic signed [SUM_W-1:0] DRIFT_MAX =
    SUM_W'((64'sd1 <<< (DRIFT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] DRIFT_MIN = -DRIFT_MAX - SUM_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SECOND,
    S_ADJ,
    S_CHUNK,
    S_MARK
  } state_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_PAD  = 2'd1,
    DIR_LATE = 2'd2
  } dir_t;

  state_t                         state_r;
  logic signed [DRIFT_WIDTH-1:0]  pending_r;
  logic [CNT_W-1:0]               nbuf_r;
  logic [CNT_W-1:0]               pos_r;
  logic [CNT_W-1:0]               chunk_r;
  logic [CNT_W-1:0]               adj_r;
  logic [CNT_W-1:0]               spare_r;
  logic [CNT_W-1:0]               hdr_quo_r;
  dir_t                           dir_r;
  logic [SAMPLE_W-1:0]            prev_l_r;
  logic [SAMPLE_W-1:0]            prev_rt_r;
  logic [MARK_W-1:0]              mark_r;
  logic [CNT_W-1:0]               marks_left_r;
  logic                           out_valid_r;
  logic [SAMPLE_W-1:0]            out_l_r;
  logic [SAMPLE_W-1:0]            out_rt_r;
  logic                           out_ins_r;
  logic                           out_end_r;
  logic [SAMPLE_W-1:0]            hold_l_r;
  logic [SAMPLE_W-1:0]            hold_rt_r;
  logic                           hold_end_r;

  logic                           out_free;
  logic signed [SUM_W-1:0]        drift_sum;
  logic signed [DRIFT_WIDTH-1:0]  pending_nxt;
  logic [CNT_W-1:0]               frames_sat;
  logic [2*CNT_W-1:0]             hdr_prod;
  logic [CNT_W-1:0]               hdr_quo;
  logic [DRIFT_WIDTH-1:0]         drift_mag;
  logic                           drift_zero;
  logic                           drift_pos;
  logic [CNT_W-1:0]               t_base;
  logic [CNT_W-1:0]               t_mag;
  logic [CNT_W-1:0]               t_pad;
  logic [CNT_W-1:0]               adj_nxt;
  dir_t                           dir_nxt;
  logic signed [DRIFT_WIDTH-1:0]  pending_adj;
  logic [2*CNT_W-1:0]             span;
  logic [MARK_W-1:0]              first_ins;
  logic signed [SAMPLE_W:0]       sum_l;
  logic signed [SAMPLE_W:0]       sum_rt;
  logic signed [SAMPLE_W:0]       rnd_l;
  logic signed [SAMPLE_W:0]       rnd_rt;
  logic                           in_buf;
  logic                           is_last;
  logic                           hit_drop;
  logic                           hit_ins;
  logic                           take_frame;

  assign out_free = !out_valid_r || out_tready;

  // Saturating add of a drift amount.
  always_comb begin
    drift_sum = SUM_W'(pending_r) + SUM_W'(q_item.drift);
    if (drift_sum > DRIFT_MAX) begin
      pending_nxt = DRIFT_WIDTH'(DRIFT_MAX);
    end else if (drift_sum < DRIFT_MIN) begin
      pending_nxt = DRIFT_WIDTH'(DRIFT_MIN);
    end else begin
      pending_nxt = DRIFT_WIDTH'(drift_sum);
    end
  end

  // Oversized frame counts are clamped to the buffer limit.
  assign frames_sat = (32'(q_item.frames) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                              : q_item.frames;

  // Frames/200 by reciprocal multiplication, taken with the header.
  assign hdr_prod = frames_sat * HDR_RECIP;
  assign hdr_quo  = CNT_W'(hdr_prod >> HDR_SHIFT);

  // Adjustment for this buffer, from frames/200 and the pending drift.
  always_comb begin
    drift_zero = (pending_r == '0);
    drift_pos  = !pending_r[DRIFT_WIDTH-1] && !drift_zero;
    drift_mag  = pending_r[DRIFT_WIDTH-1] ? DRIFT_WIDTH'(-pending_r)
                                          : DRIFT_WIDTH'(pending_r);
    t_base     = (hdr_quo_r == '0) ? CNT_W'(1) : hdr_quo_r;
    t_mag      = (32'(t_base) > 32'(drift_mag)) ? CNT_W'(drift_mag) : t_base;
    t_pad      = (t_mag > spare_r) ? spare_r : t_mag;
    if (nbuf_r < CNT_W'(2) || drift_zero) begin
      adj_nxt = '0;
      dir_nxt = DIR_NONE;
    end else if (drift_pos) begin
      adj_nxt = t_pad;
      dir_nxt = (t_pad != '0) ? DIR_PAD : DIR_NONE;
    end else begin
      adj_nxt = t_mag;
      dir_nxt = DIR_LATE;
    end
    pending_adj = drift_pos ? (pending_r - DRIFT_WIDTH'(adj_nxt))
                            : (pending_r + DRIFT_WIDTH'(adj_nxt));
  end

  // First insertion point when padding: N minus T chunks.
  assign span      = adj_r * chunk_r;
  assign first_ins = MARK_W'(nbuf_r) - MARK_W'(span);

  // Interpolated frame, each channel averaged with truncation toward zero.
  always_comb begin
    sum_l  = (SAMPLE_W+1)'(q_item.left) + (SAMPLE_W+1)'($signed(prev_l_r));
    sum_rt = (SAMPLE_W+1)'(q_item.right) + (SAMPLE_W+1)'($signed(prev_rt_r));
    rnd_l  = sum_l + $signed({{SAMPLE_W{1'b0}}, sum_l[SAMPLE_W]});
    rnd_rt = sum_rt + $signed({{SAMPLE_W{1'b0}}, sum_rt[SAMPLE_W]});
  end

  // Frame classification against the current buffer plan.
  assign in_buf   = (pos_r < nbuf_r);
  assign is_last  = ((pos_r + CNT_W'(1)) == nbuf_r);
  assign hit_drop = (dir_r == DIR_LATE) && (marks_left_r != '0) &&
                    ((MARK_W'(pos_r) + MARK_W'(1)) == mark_r);
  assign hit_ins  = (dir_r == DIR_PAD) && (marks_left_r != '0) &&
                    (MARK_W'(pos_r) == mark_r);

  assign take_frame = (state_r == S_IDLE) && q_valid && (q_item.kind == MODE_FRAME) &&
                      out_free;

  // Pop the queue head when the back end takes it in this cycle.
  always_comb begin
    q_pop = 1'b0;
    if (state_r == S_IDLE && q_valid) begin
      case (q_item.kind) inside
        MODE_DRIFT, MODE_HEADER: q_pop = 1'b1;
        MODE_FRAME:              q_pop = out_free;
        default:                 q_pop = 1'b1;
      endcase
    end
  end

  // Divider request: frames/(T+1) as soon as the adjustment is planned.
  always_comb begin
    div_req.start    = (state_r == S_ADJ);
    div_req.dividend = nbuf_r;
    div_req.divisor  = adj_nxt + CNT_W'(1);
  end

  // Sequencer with its state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pending_r    <= '0;
      nbuf_r       <= '0;
      pos_r        <= '0;
      chunk_r      <= '0;
      adj_r        <= '0;
      spare_r      <= '0;
      hdr_quo_r    <= '0;
      dir_r        <= DIR_NONE;
      prev_l_r     <= '0;
      prev_rt_r    <= '0;
      mark_r       <= '0;
      marks_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_item.kind == MODE_DRIFT) begin
            pending_r <= pending_nxt;
          end else if (q_valid && q_item.kind == MODE_HEADER) begin
            nbuf_r       <= frames_sat;
            spare_r      <= q_item.spare;
            hdr_quo_r    <= hdr_quo;
            pos_r        <= '0;
            marks_left_r <= '0;
            state_r      <= S_ADJ;
          end else if (take_frame) begin
            prev_l_r  <= q_item.left;
            prev_rt_r <= q_item.right;
            if (!in_buf) begin
              out_valid_r <= 1'b1;
              out_l_r     <= q_item.left;
              out_rt_r    <= q_item.right;
              out_ins_r   <= 1'b0;
              out_end_r   <= 1'b0;
            end else begin
              pos_r <= pos_r + CNT_W'(1);
              if (hit_drop) begin
                marks_left_r <= marks_left_r - CNT_W'(1);
                mark_r       <= mark_r + MARK_W'(chunk_r);
              end else if (hit_ins) begin
                marks_left_r <= marks_left_r - CNT_W'(1);
                mark_r       <= mark_r + MARK_W'(chunk_r);
                out_valid_r  <= 1'b1;
                out_l_r      <= rnd_l[SAMPLE_W:1];
                out_rt_r     <= rnd_rt[SAMPLE_W:1];
                out_ins_r    <= 1'b1;
                out_end_r    <= 1'b0;
                hold_l_r     <= q_item.left;
                hold_rt_r    <= q_item.right;
                hold_end_r   <= is_last;
                state_r      <= S_SECOND;
              end else begin
                out_valid_r <= 1'b1;
                out_l_r     <= q_item.left;
                out_rt_r    <= q_item.right;
                out_ins_r   <= 1'b0;
                out_end_r   <= is_last;
              end
            end
          end
        end
        S_SECOND: begin
          // The original frame follows its interpolated neighbor.
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_l_r     <= hold_l_r;
            out_rt_r    <= hold_rt_r;
            out_ins_r   <= 1'b0;
            out_end_r   <= hold_end_r;
            state_r     <= S_IDLE;
          end
        end
        S_ADJ: begin
          adj_r     <= adj_nxt;
          dir_r     <= dir_nxt;
          pending_r <= pending_adj;
          state_r   <= S_CHUNK;
        end
        S_CHUNK: begin
          if (div_rsp.done) begin
            chunk_r <= div_rsp.quotient;
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          // Late drops start one chunk in; padding starts T chunks before the end.
          mark_r       <= (dir_r == DIR_PAD) ? first_ins : MARK_W'(chunk_r);
          marks_left_r <= adj_r;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rt_r, out_l_r};
  assign out_tuser  = out_ins_r;
  assign out_tlast  = out_end_r;

endmodule

// ===== verif/audio_drift_frame_insert_drop_tb.sv =====
// Self-checking testbench for the audio drift frame insert/drop block.
module audio_drift_frame_insert_drop_tb;
  import adfid_pkg::*;

  // Item kind that the block ignores.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRIFT_MAX = 8388607;
  localparam int DRIFT_MIN = -8388608;
  localparam int FRAME_CAP = 4096;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 500;

  // Direction of the adjustment chosen at a buffer header.
  typedef enum int {ADJ_NONE, ADJ_PAD, ADJ_LATE} adjust_dir_t;

  // One frame the block is expected to emit.
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        inserted;
    logic        is_last;
  } frame_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  // Compensator state as the testbench tracks it.
  int drift_pending = 0;
  int buf_frames = 0;
  int buf_pos = 0;
  int chunk_len = 0;
  int adjust_count = 0;
  adjust_dir_t adjust_dir = ADJ_NONE;
  int prev_left = 0;
  int prev_right = 0;

  frame_exp_t expected_frames[$];
  int mismatches = 0;
  int items_sent = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;

  audio_drift_frame_insert_drop dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_frame(input int l, input int r, input logic ins,
                                     input logic lst);
    frame_exp_t f;
    f.left = l[15:0];
    f.right = r[15:0];
    f.inserted = ins;
    f.is_last = lst;
    expected_frames.push_back(f);
  endfunction

  // Apply one accepted item to the tracked state and queue the frames it yields.
  function automatic void compensate_item(input logic [1:0] kind,
                                          input logic [IN_TDATA_W-1:0] data);
    int sum, n, spare, t, p, d, q, l, r, pl, pr;
    case (kind)
      MODE_DRIFT: begin
        sum = drift_pending + int'($signed(data[23:0]));
        if (sum > DRIFT_MAX) sum = DRIFT_MAX;
        if (sum < DRIFT_MIN) sum = DRIFT_MIN;
        drift_pending = sum;
      end
      MODE_HEADER: begin
        n = int'(data[36:24]);
        spare = int'(data[49:37]);
        if (n > FRAME_CAP) n = FRAME_CAP;
        buf_frames = n;
        buf_pos = 0;
        t = n / 200;
        if (t == 0) t = 1;
        adjust_dir = ADJ_NONE;
        if (n < 2 || drift_pending == 0) begin
          t = 0;
        end else if (drift_pending > 0) begin
          if (t > drift_pending) t = drift_pending;
          if (t > spare) t = spare;
          if (t != 0) adjust_dir = ADJ_PAD;
          drift_pending -= t;
        end else begin
          if (t > -drift_pending) t = -drift_pending;
          adjust_dir = ADJ_LATE;
          drift_pending += t;
        end
        adjust_count = t;
        chunk_len = n / (t + 1);
        if (t == 0) adjust_dir = ADJ_NONE;
      end
      MODE_FRAME: begin
        l = int'($signed(data[65:50]));
        r = int'($signed(data[81:66]));
        pl = prev_left;
        pr = prev_right;
        p = buf_pos;
        prev_left = l;
        prev_right = r;
        // Frames past the end of the buffer pass through untouched.
        if (p >= buf_frames) begin
          push_frame(l, r, 1'b0, 1'b0);
          return;
        end
        buf_pos = p + 1;
        if (adjust_dir == ADJ_LATE && chunk_len != 0) begin
          q = (p + 1) / chunk_len;
          if ((p + 1) % chunk_len == 0 && q >= 1 && q <= adjust_count) return;
        end
        if (adjust_dir == ADJ_PAD && chunk_len != 0 && p > 0) begin
          d = buf_frames - p;
          q = d / chunk_len;
          if (d % chunk_len == 0 && q >= 1 && q <= adjust_count)
            push_frame((pl + l) / 2, (pr + r) / 2, 1'b1, 1'b0);
        end
        push_frame(l, r, 1'b0, (p + 1 == buf_frames));
      end
      default: ;
    endcase
  endfunction

  // Track accepted items first, then check each accepted frame.
  always @(posedge clk) begin : monitor
    frame_exp_t want;
    if (rst_n && in_tvalid && in_tready) compensate_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame L=%0d R=%0d ins=%b last=%b",
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser, out_tlast);
      end else begin
        want = expected_frames.pop_front();
        if (out_tdata[15:0] !== want.left || out_tdata[31:16] !== want.right ||
            out_tuser !== want.inserted || out_tlast !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: expected L=%0d R=%0d ins=%b last=%b, got L=%0d R=%0d ins=%b last=%b",
                     $signed(want.left), $signed(want.right), want.inserted, want.is_last,
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser, out_tlast);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Ends the run when nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_fields(
      input logic [23:0] drift, input logic [12:0] frames, input logic [12:0] spare,
      input logic [15:0] left, input logic [15:0] right);
    return {6'b0, right, left, spare, frames, drift};
  endfunction

  function automatic logic [23:0] clamp_drift(input int v);
    if (v > DRIFT_MAX) v = DRIFT_MAX;
    if (v < DRIFT_MIN) v = DRIFT_MIN;
    return v[23:0];
  endfunction

  // Offer one item, starting and ending at a falling edge.
  task automatic send_item(input logic [1:0] kind, input logic [IN_TDATA_W-1:0] data);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind != MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_drift(input logic [23:0] amount);
    send_item(MODE_DRIFT, pack_fields(amount, 13'($urandom), 13'($urandom),
                                      16'($urandom), 16'($urandom)));
  endtask

  task automatic send_header(input int n, input int spare);
    send_item(MODE_HEADER, pack_fields(24'($urandom), 13'(n), 13'(spare),
                                       16'($urandom), 16'($urandom)));
  endtask

  task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
    send_item(MODE_FRAME, pack_fields(24'($urandom), 13'($urandom), 13'($urandom), l, r));
  endtask

  task automatic send_unused();
    send_item(MODE_UNUSED, pack_fields(24'($urandom), 13'($urandom), 13'($urandom),
                                       16'($urandom), 16'($urandom)));
  endtask

  // Stop offering and wait until every expected frame has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic steer_drift(input int target);
    while (drift_pending != target) send_drift(clamp_drift(target - drift_pending));
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] pick_drift();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return clamp_drift($urandom_range(0, 1) ? $urandom_range(1, 12)
                                                        : -$urandom_range(1, 12));
    if (r < 82) return clamp_drift($urandom_range(0, 6) - 3 - drift_pending);
    if (r < 95) return 24'($urandom);
    return 24'd0;
  endfunction

  // Extremes, every item kind and each corner of the buffer handling.
  task automatic test_directed();
    send_frame(16'h7FFF, 16'h8000);          // no buffer open yet
    send_unused();
    send_drift(24'h7FFFFF);
    send_drift(24'h7FFFFF);                  // saturates high
    send_header(2, 0);                       // no spare room, no padding
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h8000, 16'h7FFF);
    send_header(2, 13'h1FFF);                // pads one frame
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h8001, 16'h7FFF);          // averages truncate toward zero
    send_header(1, 100);                     // short buffer
    send_frame(16'h1234, 16'hEDCB);
    send_frame(16'h0000, 16'h0000);          // past the end of the buffer
    send_drift(24'h800000);
    send_drift(24'h800000);                  // saturates low
    send_header(13'h1FFF, 0);                // count above the maximum
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h5555, 16'hAAAA);
    send_header(3, 0);                       // abandons the open buffer, drops one
    send_frame(16'h0101, 16'h0202);
    send_frame(16'h0303, 16'h0404);
    send_frame(16'h0505, 16'h0606);
    send_header(0, 5);
    send_frame(16'hFFFF, 16'h0001);
    wait_drained();
  endtask

  // Buffers long enough for two insertions and two drops.
  task automatic test_multi_adjust();
    steer_drift(5);
    send_header(400, 4000);
    repeat (400) send_frame(pick_sample(), pick_sample());
    steer_drift(-5);
    send_header(400, 0);
    repeat (400) send_frame(pick_sample(), pick_sample());
    wait_drained();
  endtask

  // The receiver holds off while frames keep coming, so the input stalls.
  task automatic test_output_backpressure();
    steer_drift(3);
    send_header(60, 100);
    hold_request = 300;
    repeat (60) send_frame(pick_sample(), pick_sample());
    wait_drained();
  endtask

  // Mostly whole buffers with random content, plus abandoned buffers and noise.
  task automatic test_random_buffers();
    int start, n, eff, nf, r;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start > RANDOM_ITEMS - 150) gaps_on = 1'b0;
      repeat ($urandom_range(0, 2)) send_drift(pick_drift());
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(2, 24);
      else if (r < 72) n = $urandom_range(0, 1);
      else if (r < 88) n = $urandom_range(25, 199);
      else if (r < 93) n = $urandom_range(200, 520);
      else if (r < 97) n = $urandom_range(521, FRAME_CAP);
      else n = $urandom_range(FRAME_CAP + 1, 8191);
      send_header(n, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(0, 8191));
      eff = (n > FRAME_CAP) ? FRAME_CAP : n;
      r = $urandom_range(0, 9);
      if (eff > 520) nf = $urandom_range(0, 40);
      else if (r == 0) nf = $urandom_range(0, eff);
      else if (r == 1) nf = eff + $urandom_range(1, 3);
      else nf = eff;
      repeat (nf) begin
        if ($urandom_range(0, 49) == 0) send_unused();
        send_frame(pick_sample(), pick_sample());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_multi_adjust();
    test_output_backpressure();
    test_random_buffers();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
